FILE: rtl/spq_pkg.sv
// Shared types and operation codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} spq_mem_ctl_t;

endpackage

FILE: rtl/spq_store.sv
// Entry store: one address shared by a write port and a read port, with registered read data.
`timescale 1ns / 1ps

module spq_store #(
	parameter int DEPTH          = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16,
	parameter int ADDR_W         = 4
) (
	input  logic                      clk,
	input  spq_pkg::spq_mem_ctl_t     mem_ctl,
	input  logic [ADDR_W-1:0]         addr,
	input  logic [VALUE_WIDTH-1:0]    wr_value,
	input  logic [PRIORITY_WIDTH-1:0] wr_priority,
	output logic [VALUE_WIDTH-1:0]    rd_value,
	output logic [PRIORITY_WIDTH-1:0] rd_priority
);
	import spq_pkg::*;

	logic [VALUE_WIDTH-1:0]    value_mem [DEPTH];
	logic [PRIORITY_WIDTH-1:0] prio_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			value_mem[addr] <= wr_value;
			prio_mem[addr]  <= wr_priority;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_value    <= value_mem[addr];
			rd_priority <= prio_mem[addr];
		end
	end

endmodule

FILE: rtl/spq_ctrl.sv
// Sequencer with the shared priority compare and ring address unit.
`timescale 1ns / 1ps

module spq_ctrl #(
	parameter int CAPACITY       = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16,
	parameter int ADDR_W         = 4,
	parameter int CNT_W          = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             mode,
	input  logic [VALUE_WIDTH-1:0]           item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             idle,
	output spq_pkg::spq_mem_ctl_t            mem_ctl,
	output logic [ADDR_W-1:0]                mem_addr,
	output logic [VALUE_WIDTH-1:0]           wr_value,
	output logic [PRIORITY_WIDTH-1:0]        wr_priority,
	input  logic [VALUE_WIDTH-1:0]           rd_value,
	input  logic [PRIORITY_WIDTH-1:0]        rd_priority,
	input  logic                             res_ready,
	output logic                             res_load,
	output logic                             res_accepted,
	output logic [VALUE_WIDTH-1:0]           res_head_value,
	output logic signed [PRIORITY_WIDTH-1:0] res_head_priority,
	output logic                             res_empty,
	output logic [CNT_W-1:0]                 res_count
);
	import spq_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EREAD = 3'd1;
	localparam logic [2:0] ST_ECMP  = 3'd2;
	localparam logic [2:0] ST_HEAD  = 3'd3;
	localparam logic [2:0] ST_HWAIT = 3'd4;

	localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [ADDR_W:0]   CAP_EXT = (ADDR_W + 1)'(CAPACITY);
	localparam logic [ADDR_W-1:0] LAST    = ADDR_W'(CAPACITY - 1);

	logic [2:0]                      state_q;
	logic [CNT_W-1:0]                count_q;
	logic [ADDR_W-1:0]               head_q;
	logic [ADDR_W-1:0]               pos_q;
	logic [VALUE_WIDTH-1:0]          new_value_q;
	logic signed [PRIORITY_WIDTH-1:0] new_prio_q;
	logic                            acc_q;

	logic [ADDR_W-1:0] lidx;
	logic [ADDR_W:0]   ring_sum;
	logic              moves_down;

	// logical index to ring address: one add and one wrap compare
	always_comb begin
		case (state_q)
			ST_EREAD: lidx = (pos_q != '0) ? pos_q - ADDR_W'(1) : pos_q;
			ST_ECMP:  lidx = pos_q;
			default:  lidx = '0;
		endcase
		ring_sum = {1'b0, head_q} + {1'b0, lidx};
		if (ring_sum >= CAP_EXT) begin
			mem_addr = ADDR_W'(ring_sum - CAP_EXT);
		end else begin
			mem_addr = ring_sum[ADDR_W-1:0];
		end
	end

	// shared compare: the held entry yields its slot only to a strictly lower number
	assign moves_down = $signed(rd_priority) > new_prio_q;

	always_comb begin
		mem_ctl.wr_en = 1'b0;
		mem_ctl.rd_en = 1'b0;
		wr_value      = new_value_q;
		wr_priority   = new_prio_q;
		case (state_q)
			ST_EREAD: begin
				if (pos_q == '0) begin
					mem_ctl.wr_en = 1'b1;
				end else begin
					mem_ctl.rd_en = 1'b1;
				end
			end
			ST_ECMP: begin
				mem_ctl.wr_en = 1'b1;
				if (moves_down) begin
					wr_value    = rd_value;
					wr_priority = rd_priority;
				end
			end
			ST_HEAD:  mem_ctl.rd_en = 1'b1;
			default:  ;
		endcase
	end

	assign idle              = (state_q == ST_IDLE);
	assign res_load          = (state_q == ST_HWAIT) && res_ready;
	assign res_accepted      = acc_q;
	assign res_empty         = (count_q == '0);
	assign res_count         = count_q;
	assign res_head_value    = res_empty ? '0 : rd_value;
	assign res_head_priority = res_empty ? '0 : $signed(rd_priority);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			head_q  <= '0;
			pos_q   <= '0;
			acc_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (mode == MODE_ENQ) begin
							if (count_q != CAP_CNT) begin
								acc_q   <= 1'b1;
								pos_q   <= count_q[ADDR_W-1:0];
								count_q <= count_q + CNT_W'(1);
								state_q <= ST_EREAD;
							end else begin
								acc_q   <= 1'b0;
								state_q <= ST_HEAD;
							end
						end else begin
							state_q <= ST_HEAD;
							if (count_q != '0) begin
								acc_q   <= 1'b1;
								count_q <= count_q - CNT_W'(1);
								head_q  <= (head_q == LAST) ? '0 : head_q + ADDR_W'(1);
							end else begin
								acc_q   <= 1'b0;
							end
						end
					end
				end
				ST_EREAD: begin
					state_q <= (pos_q == '0) ? ST_HEAD : ST_ECMP;
				end
				ST_ECMP: begin
					if (moves_down) begin
						pos_q   <= pos_q - ADDR_W'(1);
						state_q <= ST_EREAD;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD:  state_q <= ST_HWAIT;
				ST_HWAIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (idle && start) begin
			new_value_q <= item_value;
			new_prio_q  <= item_priority;
		end
	end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: store, sequencer and result register.
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   in_valid / in_ready    mode, item_value, item_priority
// result    out_valid / out_ready  accepted, head_value, head_priority,
//                                  queue_empty, entry_count
//
// Entries sit in a ring buffer in one single-port store; a dequeue only advances
// the head pointer and lowers the count. An enqueue walks from the tail toward
// the head, one entry at a time through the shared compare unit (read, then
// compare and write); the store's single port keeps the read and the write of
// each entry in separate states.
// Reset clears count, head pointer and handshake state; the store is not cleared.
// A stalled result holds in the output register; the next request is taken
// while it waits and stalls only when its own result is ready to load.

module sorted_priority_queue #(
	parameter int CAPACITY       = 16,
	parameter int VALUE_WIDTH    = 32,
	parameter int PRIORITY_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [VALUE_WIDTH-1:0]           item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             accepted,
	output logic [VALUE_WIDTH-1:0]           head_value,
	output logic signed [PRIORITY_WIDTH-1:0] head_priority,
	output logic                             queue_empty,
	output logic [$clog2(CAPACITY+1)-1:0]    entry_count
);
	import spq_pkg::*;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	spq_mem_ctl_t                    mem_ctl;
	logic [ADDR_W-1:0]               mem_addr;
	logic [VALUE_WIDTH-1:0]          wr_value;
	logic [PRIORITY_WIDTH-1:0]       wr_priority;
	logic [VALUE_WIDTH-1:0]          rd_value;
	logic [PRIORITY_WIDTH-1:0]       rd_priority;

	logic                            idle;
	logic                            start;
	logic                            res_ready;
	logic                            res_load;
	logic                            res_accepted;
	logic [VALUE_WIDTH-1:0]          res_head_value;
	logic signed [PRIORITY_WIDTH-1:0] res_head_priority;
	logic                            res_empty;
	logic [CNT_W-1:0]                res_count;

	logic                            out_valid_q;
	logic                            accepted_q;
	logic [VALUE_WIDTH-1:0]          head_value_q;
	logic signed [PRIORITY_WIDTH-1:0] head_priority_q;
	logic                            queue_empty_q;
	logic [CNT_W-1:0]                entry_count_q;

	// take a request whenever the sequencer is idle
	assign in_ready = idle;
	assign start    = in_valid && idle;

	// load a new result when the output register is free or draining this cycle
	assign res_ready = !out_valid_q || out_ready;

	spq_store #(
		.DEPTH          (CAPACITY),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.ADDR_W         (ADDR_W)
	) u_store (
		.clk         (clk),
		.mem_ctl     (mem_ctl),
		.addr        (mem_addr),
		.wr_value    (wr_value),
		.wr_priority (wr_priority),
		.rd_value    (rd_value),
		.rd_priority (rd_priority)
	);

	spq_ctrl #(
		.CAPACITY       (CAPACITY),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.ADDR_W         (ADDR_W),
		.CNT_W          (CNT_W)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.mode              (mode),
		.item_value        (item_value),
		.item_priority     (item_priority),
		.idle              (idle),
		.mem_ctl           (mem_ctl),
		.mem_addr          (mem_addr),
		.wr_value          (wr_value),
		.wr_priority       (wr_priority),
		.rd_value          (rd_value),
		.rd_priority       (rd_priority),
		.res_ready         (res_ready),
		.res_load          (res_load),
		.res_accepted      (res_accepted),
		.res_head_value    (res_head_value),
		.res_head_priority (res_head_priority),
		.res_empty         (res_empty),
		.res_count         (res_count)
	);

	// hold valid until taken; a load in the same cycle keeps it high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			accepted_q      <= res_accepted;
			head_value_q    <= res_head_value;
			head_priority_q <= res_head_priority;
			queue_empty_q   <= res_empty;
			entry_count_q   <= res_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign head_value    = head_value_q;
	assign head_priority = head_priority_q;
	assign queue_empty   = queue_empty_q;
	assign entry_count   = entry_count_q;

endmodule
